FILE: rtl/core/irnrz_pkg.sv
`timescale 1ns / 1ps

package irnrz_pkg;

  // Field widths
  localparam int DUR_W  = 24;
  localparam int TIME_W = 16;
  localparam int RUN_W  = 8;

  // Longest run, in bits, before it is sent and a new run begins
  localparam int MAX_RUN = 255;

  // Register reset values, in microseconds
  localparam logic [TIME_W-1:0] BIT_TIME_RESET       = 16'd800;
  localparam logic [TIME_W-1:0] PREAMBLE_LONG_RESET  = 16'd7600;
  localparam logic [TIME_W-1:0] PREAMBLE_SHORT_RESET = 16'd800;

  // Register map: index is paddr[3:2]
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 2;
  localparam logic [IDX_W-1:0] REG_BIT_TIME       = 2'd0;
  localparam logic [IDX_W-1:0] REG_PREAMBLE_LONG  = 2'd1;
  localparam logic [IDX_W-1:0] REG_PREAMBLE_SHORT = 2'd2;

  // Pulses that one frame bit can give rise to, and the candidates they are picked from
  localparam int MAX_PULSES = 6;
  localparam int CAND_NUM   = 8;
  localparam int CNT_W      = $clog2(MAX_PULSES + 1);

  // Pulse queue
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = PTR_W + 1;

  typedef struct packed {
    logic bit_value;
    logic last_bit;
  } bit_item_t;

  typedef struct packed {
    logic             is_mark;
    logic [DUR_W-1:0] duration_us;
    logic             end_of_frame;
  } pulse_t;

  typedef struct packed {
    logic [TIME_W-1:0] bit_time_us;
    logic [TIME_W-1:0] preamble_long_us;
    logic [TIME_W-1:0] preamble_short_us;
  } cfg_t;

  typedef struct packed {
    pulse_t [MAX_PULSES-1:0] pulse;
    logic   [CNT_W-1:0]      count;
  } pulse_batch_t;

endpackage

FILE: rtl/core/ir_nrz_pulse_encoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// bit       in         bit_valid / bit_stall    bit_data   (bit_value, last_bit)
// pulse     out        pulse_valid / pulse_stall pulse_data (is_mark, duration_us,
//                                                            end_of_frame)
// config    in         APB write/read           paddr, pwdata, prdata
//
// A bit transaction waits in a holding register, which reloads as it empties, and is then
// turned into all its pulses at once, given six free entries in the eight-entry queue. Its
// pulses pass through the holding register and the queue; they leave one per cycle while
// pulse_stall is low. A frame's first bit gives four or six pulses, its last bit two or three,
// any other bit none or one. Synchronous reset clears the run state, queue and holding
// register and sets 800, 7600, 800 us. A stalled pulse fills the queue, then stalls bits.

module ir_nrz_pulse_encoder (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             bit_valid,
  output logic                             bit_stall,
  input  irnrz_pkg::bit_item_t             bit_data,

  output logic                             pulse_valid,
  input  logic                             pulse_stall,
  output irnrz_pkg::pulse_t                pulse_data,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [irnrz_pkg::ADDR_W-1:0]     paddr,
  input  logic [irnrz_pkg::DATA_W-1:0]     pwdata,
  output logic [irnrz_pkg::DATA_W-1:0]     prdata,
  output logic                             pready
);

  irnrz_pkg::cfg_t          cfg;
  irnrz_pkg::bit_item_t     hold_item;
  logic                     hold_valid;
  logic                     room;
  logic                     fire;
  logic                     cfg_write;
  logic [irnrz_pkg::IDX_W-1:0] reg_idx;
  irnrz_pkg::pulse_batch_t  batch;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land in the access phase; reads are
  // combinational from the register selected by the word address.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[irnrz_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_time_us       <= irnrz_pkg::BIT_TIME_RESET;
      cfg.preamble_long_us  <= irnrz_pkg::PREAMBLE_LONG_RESET;
      cfg.preamble_short_us <= irnrz_pkg::PREAMBLE_SHORT_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        irnrz_pkg::REG_BIT_TIME: begin
          cfg.bit_time_us <= pwdata[irnrz_pkg::TIME_W-1:0];
        end
        irnrz_pkg::REG_PREAMBLE_LONG: begin
          cfg.preamble_long_us <= pwdata[irnrz_pkg::TIME_W-1:0];
        end
        irnrz_pkg::REG_PREAMBLE_SHORT: begin
          cfg.preamble_short_us <= pwdata[irnrz_pkg::TIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      irnrz_pkg::REG_BIT_TIME:       prdata = irnrz_pkg::DATA_W'(cfg.bit_time_us);
      irnrz_pkg::REG_PREAMBLE_LONG:  prdata = irnrz_pkg::DATA_W'(cfg.preamble_long_us);
      irnrz_pkg::REG_PREAMBLE_SHORT: prdata = irnrz_pkg::DATA_W'(cfg.preamble_short_us);
      default:                       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Holding register for the incoming bit. It is processed as soon as the
  // pulse queue can take the largest possible batch, and it reloads in the
  // same cycle, so the bit channel only stalls when the queue is backed up.
  // ---------------------------------------------------------------------------
  assign fire      = hold_valid && room;
  assign bit_stall = hold_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (bit_valid && !bit_stall) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bit_valid && !bit_stall) begin
      hold_item <= bit_data;
    end
  end

  // Run-length state and the preamble, run and trailing-mark pulses.
  irnrz_pulse_gen u_gen (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (hold_item),
    .cfg   (cfg),
    .batch (batch)
  );

  // Pulses wait here until the output side takes them, one per cycle while it does not stall.
  irnrz_pulse_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fire),
    .wr_batch (batch),
    .room     (room),
    .rd_valid (pulse_valid),
    .rd_stall (pulse_stall),
    .rd_data  (pulse_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A bit that produced pulses is visible at the output in the next cycle.
  a_batch_shows: assert property (@(posedge clk) disable iff (rst)
    fire && (batch.count != '0) |=> pulse_valid)
    else $error("pulses of a processed bit did not reach the output");

  // A held bit that cannot be processed stays put.
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !fire |=> hold_valid && $stable(hold_item))
    else $error("held bit lost while the pulse queue was full");

  // The end of a frame is always a mark.
  a_eof_mark: assert property (@(posedge clk) disable iff (rst)
    pulse_valid && pulse_data.end_of_frame |-> pulse_data.is_mark)
    else $error("end-of-frame pulse is not a mark");

  // A last bit always closes its batch with the end-of-frame mark.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    fire && hold_item.last_bit |-> (batch.count != '0))
    else $error("last bit produced no trailing mark");

endmodule

FILE: rtl/core/irnrz_pulse_gen.sv
`timescale 1ns / 1ps

module irnrz_pulse_gen (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  irnrz_pkg::bit_item_t  item,
  input  irnrz_pkg::cfg_t       cfg,
  output irnrz_pkg::pulse_batch_t batch
);

  logic                       in_frame;
  logic                       run_level;
  logic [irnrz_pkg::RUN_W-1:0] run_length;

  logic                        pre;
  logic [irnrz_pkg::RUN_W-1:0] len0;
  logic                        flush_a;
  logic [irnrz_pkg::RUN_W-1:0] len_a;
  logic                        lvl1;
  logic [irnrz_pkg::RUN_W-1:0] len1;
  logic                        flush_b;
  logic [irnrz_pkg::RUN_W-1:0] len_b;
  logic                        flush_c;
  logic [irnrz_pkg::DUR_W-1:0] prod_a;
  logic [irnrz_pkg::DUR_W-1:0] prod_b;
  logic [irnrz_pkg::DUR_W-1:0] long_dur;
  logic [irnrz_pkg::DUR_W-1:0] short_dur;
  logic [irnrz_pkg::DUR_W-1:0] bit_dur;

  irnrz_pkg::pulse_t [irnrz_pkg::CAND_NUM-1:0] cand;
  logic [irnrz_pkg::CAND_NUM-1:0]              en;
  logic [irnrz_pkg::CNT_W-1:0]                 n;

  // Run tracking for the bit now being taken in.
  always_comb begin
    pre     = ~in_frame;
    len0    = pre ? '0 : run_length;
    flush_a = (len0 != '0) && (item.bit_value != run_level);
    len_a   = flush_a ? '0 : len0;
    lvl1    = (len_a == '0) ? item.bit_value : run_level;
    len1    = len_a + 8'd1;
    flush_b = (len1 >= irnrz_pkg::RUN_W'(irnrz_pkg::MAX_RUN));
    len_b   = flush_b ? '0 : len1;
    flush_c = item.last_bit && (len_b != '0);
  end

  assign prod_a    = irnrz_pkg::DUR_W'(len0) * irnrz_pkg::DUR_W'(cfg.bit_time_us);
  assign prod_b    = irnrz_pkg::DUR_W'(len1) * irnrz_pkg::DUR_W'(cfg.bit_time_us);
  assign long_dur  = irnrz_pkg::DUR_W'(cfg.preamble_long_us);
  assign short_dur = irnrz_pkg::DUR_W'(cfg.preamble_short_us);
  assign bit_dur   = irnrz_pkg::DUR_W'(cfg.bit_time_us);

  // Candidates in the order they leave the block.
  always_comb begin
    cand[0] = '{is_mark: 1'b1, duration_us: long_dur,  end_of_frame: 1'b0};
    cand[1] = '{is_mark: 1'b0, duration_us: short_dur, end_of_frame: 1'b0};
    cand[2] = '{is_mark: 1'b1, duration_us: short_dur, end_of_frame: 1'b0};
    cand[3] = '{is_mark: 1'b0, duration_us: long_dur,  end_of_frame: 1'b0};
    cand[4] = '{is_mark: run_level, duration_us: prod_a, end_of_frame: 1'b0};
    cand[5] = '{is_mark: lvl1, duration_us: prod_b, end_of_frame: 1'b0};
    cand[6] = '{is_mark: lvl1, duration_us: prod_b, end_of_frame: 1'b0};
    cand[7] = '{is_mark: 1'b1, duration_us: bit_dur, end_of_frame: 1'b1};
    en = {item.last_bit, flush_c, flush_b, flush_a, pre, pre, pre, pre};
  end

  // Pack the enabled candidates into consecutive slots.
  always_comb begin
    batch = '0;
    n     = '0;
    for (int i = 0; i < irnrz_pkg::CAND_NUM; i++) begin
      if (en[i] && (n < irnrz_pkg::CNT_W'(irnrz_pkg::MAX_PULSES))) begin
        batch.pulse[n] = cand[i];
        n              = n + irnrz_pkg::CNT_W'(1);
      end
    end
    batch.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      run_level  <= 1'b0;
      run_length <= '0;
    end else if (fire) begin
      if (item.last_bit) begin
        in_frame   <= 1'b0;
        run_level  <= 1'b0;
        run_length <= '0;
      end else begin
        in_frame   <= 1'b1;
        run_level  <= lvl1;
        run_length <= len_b;
      end
    end
  end

endmodule

FILE: rtl/core/irnrz_pulse_fifo.sv
`timescale 1ns / 1ps

module irnrz_pulse_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  irnrz_pkg::pulse_batch_t wr_batch,
  output logic                    room,
  output logic                    rd_valid,
  input  logic                    rd_stall,
  output irnrz_pkg::pulse_t       rd_data
);

  irnrz_pkg::pulse_t [irnrz_pkg::FIFO_DEPTH-1:0] mem;

  logic [irnrz_pkg::PTR_W-1:0] wr_ptr;
  logic [irnrz_pkg::PTR_W-1:0] rd_ptr;
  logic [irnrz_pkg::LVL_W-1:0] level;
  logic [irnrz_pkg::CNT_W-1:0] wr_num;
  logic                        pop;

  // A whole batch must fit before an item is processed.
  assign room     = (level <= irnrz_pkg::LVL_W'(irnrz_pkg::FIFO_DEPTH - irnrz_pkg::MAX_PULSES));
  assign rd_valid = (level != '0);
  assign rd_data  = mem[rd_ptr];
  assign pop      = rd_valid && !rd_stall;
  assign wr_num   = wr_en ? wr_batch.count : '0;

  always_ff @(posedge clk) begin
    for (int k = 0; k < irnrz_pkg::MAX_PULSES; k++) begin
      if (wr_en && (irnrz_pkg::CNT_W'(k) < wr_batch.count)) begin
        mem[wr_ptr + irnrz_pkg::PTR_W'(k)] <= wr_batch.pulse[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + irnrz_pkg::PTR_W'(wr_num);
      rd_ptr <= rd_ptr + irnrz_pkg::PTR_W'(pop);
      level  <= level + irnrz_pkg::LVL_W'(wr_num) - irnrz_pkg::LVL_W'(pop);
    end
  end

endmodule
